>>> rtl/bfm_pkg.sv
// Shared constants, controller states and command/status types for the
// two-dimensional box mean block. No dependencies.
package bfm_pkg;

    localparam int MAX_WINDOW  = 15;
    localparam int MAX_COLUMNS = 2048;
    localparam int CHANNELS    = 4;
    localparam int RING_ROWS   = 2 * MAX_WINDOW;

    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int RING_W  = $clog2(RING_ROWS);
    localparam int ADDR_W  = RING_W + COL_W;
    localparam int DEPTH   = RING_ROWS * MAX_COLUMNS;
    localparam int CNT_W   = 28;
    localparam int SUM_W   = 16;
    localparam int DIVSTEP = SUM_W;

    typedef enum logic [1:0] {
        CFG_WIDTH = 2'd0,
        CFG_COLS  = 2'd1,
        CFG_ROWS  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUMI,
        ST_SUM,
        ST_FLUSH,
        ST_DIVI,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic sum_init;
        logic sum_run;
        logic div_init;
        logic div_run;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic due;
        logic sum_last;
        logic div_last;
    } t_status;

endpackage

>>> rtl/bfm_in_if.sv
// Pixel request channel: valid/ready handshake and one four-channel pixel.
// Depends on nothing.
interface bfm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic [7:0] chan3;
    logic       filler;

    modport source (output valid, chan0, chan1, chan2, chan3, filler, input ready);
    modport sink   (input valid, chan0, chan1, chan2, chan3, filler, output ready);
endinterface

>>> rtl/bfm_out_if.sv
// Result request channel: valid/ready handshake and one filtered pixel.
// Depends on nothing.
interface bfm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_chan0;
    logic [7:0] out_chan1;
    logic [7:0] out_chan2;
    logic [7:0] out_chan3;
    logic       frame_done;

    modport source (output valid, out_chan0, out_chan1, out_chan2, out_chan3, frame_done,
                    input ready);
    modport sink   (input valid, out_chan0, out_chan1, out_chan2, out_chan3, frame_done,
                    output ready);
endinterface

>>> rtl/box_filter_mean_2d_unit.sv
// Top level of the two-dimensional box mean block: controller plus datapath.
// Depends on bfm_pkg, bfm_in_if, bfm_out_if, bfm_ctrl, bfm_datapath.
//
//  channel   direction  handshake      payload
//  i_pix     in         valid/ready    chan0..chan3, filler
//  o_res     out        valid/ready    out_chan0..out_chan3, frame_done
//  i_cfg_*   in         write enable   index (2 bits), data (16 bits)
//
// An item with no result passes only through the check state; one with a result
// also runs the window sum, one line store read per window pixel, and the 16-step
// divider, then waits out any output stall. One item is in flight at a time.
// Reset is synchronous, active low, and restores width 3, 640 x 480.
// A stalled result holds in its register until taken.
module box_filter_mean_2d_unit
    import bfm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bfm_in_if.sink      i_pix,
    bfm_out_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cmd        cmd;
    t_status     st;
    logic [31:0] result;

    bfm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .o_in_ready  (i_pix.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    bfm_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pixel    ({i_pix.chan3, i_pix.chan2, i_pix.chan1, i_pix.chan0}),
        .i_filler   (i_pix.filler),
        .i_cmd      (cmd),
        .o_st       (st),
        .o_result   (result),
        .o_done     (o_res.frame_done)
    );

    assign o_res.out_chan0 = result[7:0];
    assign o_res.out_chan1 = result[15:8];
    assign o_res.out_chan2 = result[23:16];
    assign o_res.out_chan3 = result[31:24];

endmodule

>>> rtl/bfm_ctrl.sv
// Controller state machine: sequences store, window sum, divide and output.
// Depends on bfm_pkg.
module bfm_ctrl
    import bfm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_CHECK;
            ST_CHECK: n_state = i_st.due ? ST_SUMI : ST_IDLE;
            ST_SUMI:  n_state = ST_SUM;
            ST_SUM:   if (i_st.sum_last) n_state = ST_FLUSH;
            ST_FLUSH: n_state = ST_DIVI;
            ST_DIVI:  n_state = ST_DIV;
            ST_DIV:   if (i_st.div_last) n_state = ST_OUT;
            ST_OUT:   if (i_out_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_SUMI: o_cmd.sum_init = 1'b1;
            ST_SUM:  o_cmd.sum_run  = 1'b1;
            ST_DIVI: o_cmd.div_init = 1'b1;
            ST_DIV:  o_cmd.div_run  = 1'b1;
            ST_OUT: begin
                o_out_valid   = 1'b1;
                o_cmd.advance = i_out_ready;
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/bfm_datapath.sv
// Datapath: configuration, position counters, line store, window
// accumulator and per-channel serial divider. Depends on bfm_pkg.
module bfm_datapath
    import bfm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic [31:0] i_pixel,
    input  logic        i_filler,
    input  t_cmd        i_cmd,
    output t_status     o_st,
    output logic [31:0] o_result,
    output logic        o_done
);

    logic [3:0]  r_fw;
    logic [11:0] r_cols_cfg;
    logic [15:0] r_rows_cfg;

    logic [3:0]  w;
    logic [2:0]  hw;
    logic [7:0]  ww;
    logic [11:0] cols;
    logic [15:0] rows;

    always_comb begin
        w = r_fw | 4'd1;
        if (32'(w) > MAX_WINDOW) begin
            w = 4'(MAX_WINDOW - ((MAX_WINDOW + 1) % 2));
        end
        hw   = w[3:1];
        ww   = 8'(w * w);
        cols = r_cols_cfg;
        if (cols == 12'd0) cols = 12'd1;
        if (32'(cols) > MAX_COLUMNS) cols = 12'(MAX_COLUMNS);
        rows = (r_rows_cfg == 16'd0) ? 16'd1 : r_rows_cfg;
    end

    logic [CNT_W-1:0] r_total, r_lag;

    // frame size and output lag are registered and settle in the cycle after a register write
    always_ff @(posedge i_clk) begin
        r_total <= CNT_W'(rows * cols);
        r_lag   <= CNT_W'(hw * cols) + CNT_W'(hw);
    end

    logic [COL_W-1:0]  r_in_col, r_out_col;
    logic [RING_W-1:0] r_in_ring, r_out_ring;
    logic [CNT_W-1:0]  r_recv, r_o;
    logic [15:0]       r_out_row;
    logic              store;
    logic [CNT_W-1:0]  need;

    assign store = i_cmd.accept && !i_filler && (r_recv < r_total);

    always_comb begin
        need = r_o + r_lag + CNT_W'(1);
        if (need > r_total) need = r_total;
    end

    logic r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw       <= 4'd3;
            r_cols_cfg <= 12'd640;
            r_rows_cfg <= 16'd480;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH: r_fw       <= i_cfg_data[3:0];
                CFG_COLS:  r_cols_cfg <= i_cfg_data[11:0];
                CFG_ROWS:  r_rows_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_we && i_cfg_idx <= CFG_ROWS) || (i_cmd.advance && r_done)) begin
            r_in_col   <= '0;
            r_in_ring  <= '0;
            r_recv     <= '0;
            r_out_col  <= '0;
            r_out_ring <= '0;
            r_out_row  <= '0;
            r_o        <= '0;
        end else begin
            if (store) begin
                r_recv <= r_recv + CNT_W'(1);
                if (12'(r_in_col) + 12'd1 >= cols) begin
                    r_in_col  <= '0;
                    r_in_ring <= (32'(r_in_ring) == RING_ROWS - 1) ? '0
                                                                   : r_in_ring + RING_W'(1);
                end else begin
                    r_in_col <= r_in_col + COL_W'(1);
                end
            end
            if (i_cmd.advance) begin
                r_o <= r_o + CNT_W'(1);
                if (12'(r_out_col) + 12'd1 >= cols) begin
                    r_out_col  <= '0;
                    r_out_row  <= r_out_row + 16'd1;
                    r_out_ring <= (32'(r_out_ring) == RING_ROWS - 1) ? '0
                                                                     : r_out_ring + RING_W'(1);
                end else begin
                    r_out_col <= r_out_col + COL_W'(1);
                end
            end
        end
    end

    // line store
    logic [31:0]       mem [0:DEPTH-1];
    logic [31:0]       r_rdata;
    logic              r_rd_vld;
    logic [ADDR_W-1:0] rd_addr;

    always_ff @(posedge i_clk) begin
        if (store) begin
            mem[{r_in_ring, r_in_col}] <= i_pixel;
        end
    end

    // window walk
    logic [3:0]               r_wi, r_wj;
    logic signed [17:0]       r_rr;
    logic signed [COL_W+1:0]  r_cc;
    logic [RING_W-1:0]        r_rring;
    logic signed [COL_W+1:0]  cc_start;
    logic signed [RING_W:0]   ring_start;
    logic                     in_range;

    assign cc_start   = $signed({2'b00, r_out_col}) - $signed((COL_W+2)'(hw));
    assign ring_start = $signed({1'b0, r_out_ring}) - $signed((RING_W+1)'(hw));
    assign in_range   = (r_rr >= 0) && (r_rr < $signed({2'b00, rows}))
                     && (r_cc >= 0) && (r_cc < $signed({1'b0, cols}));
    assign rd_addr    = {r_rring, r_cc[COL_W-1:0]};
    assign o_st.sum_last = (r_wi == w - 4'd1) && (r_wj == w - 4'd1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_init) begin
            r_wi    <= '0;
            r_wj    <= '0;
            r_rr    <= $signed({2'b00, r_out_row}) - $signed(18'(hw));
            r_cc    <= cc_start;
            r_rring <= (ring_start < 0) ? RING_W'(ring_start + (RING_W+1)'(RING_ROWS))
                                        : RING_W'(ring_start);
        end else if (i_cmd.sum_run) begin
            if (r_wj == w - 4'd1) begin
                r_wj    <= '0;
                r_cc    <= cc_start;
                r_wi    <= r_wi + 4'd1;
                r_rr    <= r_rr + 18'sd1;
                r_rring <= (32'(r_rring) == RING_ROWS - 1) ? '0 : r_rring + RING_W'(1);
            end else begin
                r_wj <= r_wj + 4'd1;
                r_cc <= r_cc + $signed((COL_W+2)'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.sum_run && in_range;
        end
        r_rdata <= mem[rd_addr];
    end

    // accumulate, then divide each lane by w*w one quotient bit a cycle
    logic [SUM_W-1:0] r_sum [CHANNELS];
    logic [SUM_W-1:0] r_quo [CHANNELS];
    logic [7:0]       r_rem [CHANNELS];
    logic [3:0]       r_dcnt;

    assign o_st.div_last = (32'(r_dcnt) == DIVSTEP - 1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) r_dcnt <= '0;
        else if (i_cmd.div_run) r_dcnt <= r_dcnt + 4'd1;
        if (i_cmd.div_init) r_done <= (r_o + CNT_W'(1) >= r_total);
    end

    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
        logic [8:0] trial;
        assign trial = {r_rem[ch], r_quo[ch][SUM_W-1]};

        always_ff @(posedge i_clk) begin
            if (i_cmd.sum_init) begin
                r_sum[ch] <= '0;
            end else if (r_rd_vld) begin
                r_sum[ch] <= r_sum[ch] + SUM_W'(r_rdata[8*ch +: 8]);
            end
            if (i_cmd.div_init) begin
                r_quo[ch] <= r_sum[ch];
                r_rem[ch] <= '0;
            end else if (i_cmd.div_run) begin
                if (trial >= {1'b0, ww}) begin
                    r_rem[ch] <= 8'(trial - {1'b0, ww});
                    r_quo[ch] <= {r_quo[ch][SUM_W-2:0], 1'b1};
                end else begin
                    r_rem[ch] <= trial[7:0];
                    r_quo[ch] <= {r_quo[ch][SUM_W-2:0], 1'b0};
                end
            end
        end

        assign o_result[8*ch +: 8] = r_quo[ch][7:0];
    end

    if (CHANNELS < 4) begin : g_unused
        assign o_result[31:8*CHANNELS] = '0;
    end

    assign o_st.due = (r_recv >= need);
    assign o_done   = r_done;

endmodule

>>> tb/sv/tb_box_filter_mean_2d_unit.sv
// Testbench for box_filter_mean_2d_unit: random and directed frames, scoreboard class
// with its own window-mean predictor. Depends on bfm_pkg, bfm_in_if, bfm_out_if and the RTL.
`timescale 1ns / 1ps

module tb_box_filter_mean_2d_unit;
    import bfm_pkg::*;

    localparam int IDLE_LIMIT  = 5000;
    localparam int SETTLE      = 30;
    localparam int TAIL_CYCLES = 300;

    typedef struct packed {
        logic [7:0] c3;
        logic [7:0] c2;
        logic [7:0] c1;
        logic [7:0] c0;
        logic       filler;
    } t_pixel;

    typedef struct packed {
        logic [7:0] c3;
        logic [7:0] c2;
        logic [7:0] c1;
        logic [7:0] c0;
        logic       done;
    } t_mean;

    class mean_scoreboard;
        bit [3:0]    width_reg;
        bit [11:0]   cols_reg;
        bit [15:0]   rows_reg;
        int unsigned in_row, in_col, out_row, out_col;
        bit [31:0]   rows_ring [RING_ROWS*MAX_COLUMNS];
        t_mean       means_due [$];
        int          mismatches;

        function new();
            width_reg  = 4'd3;
            cols_reg   = 12'd640;
            rows_reg   = 16'd480;
            mismatches = 0;
            clear_pos();
        endfunction

        function void clear_pos();
            in_row  = 0;
            in_col  = 0;
            out_row = 0;
            out_col = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, bit [15:0] data);
            case (idx)
                CFG_WIDTH: width_reg = data[3:0];
                CFG_COLS:  cols_reg  = data[11:0];
                CFG_ROWS:  rows_reg  = data[15:0];
                default:   return;
            endcase
            clear_pos();
        endfunction

        function int unsigned win();
            int unsigned w;
            w = width_reg | 1;
            if (w > MAX_WINDOW) begin
                w = MAX_WINDOW;
                if (w % 2 == 0) w = w - 1;
            end
            return w;
        endfunction

        function int unsigned ncols();
            if (cols_reg < 1) return 1;
            if (cols_reg > MAX_COLUMNS) return MAX_COLUMNS;
            return cols_reg;
        endfunction

        function int unsigned nrows();
            return (rows_reg < 1) ? 1 : rows_reg;
        endfunction

        function bit frame_open();
            return (in_row | in_col | out_row | out_col) != 0;
        endfunction

        function void note_pixel(t_pixel p);
            int unsigned w, hw, cols, rows, total, recv, o, need;
            int unsigned sum [4];
            int          rr, cc;
            bit [31:0]   px;
            t_mean       m;
            w     = win();
            hw    = w / 2;
            cols  = ncols();
            rows  = nrows();
            total = rows * cols;
            recv  = in_row * cols + in_col;
            if (!p.filler && recv < total) begin
                rows_ring[(in_row % RING_ROWS) * MAX_COLUMNS + in_col] = {p.c3, p.c2, p.c1, p.c0};
                in_col++;
                if (in_col >= cols) begin
                    in_col = 0;
                    in_row++;
                end
                recv++;
            end
            o    = out_row * cols + out_col;
            need = o + hw * cols + hw + 1;
            if (need > total) need = total;
            if (recv < need) return;
            foreach (sum[k]) sum[k] = 0;
            for (int dr = -int'(hw); dr <= int'(hw); dr++) begin
                rr = int'(out_row) + dr;
                if (rr < 0 || rr >= int'(rows)) continue;
                for (int dc = -int'(hw); dc <= int'(hw); dc++) begin
                    cc = int'(out_col) + dc;
                    if (cc < 0 || cc >= int'(cols)) continue;
                    px = rows_ring[(rr % RING_ROWS) * MAX_COLUMNS + cc];
                    for (int k = 0; k < 4; k++) sum[k] += px[8*k +: 8];
                end
            end
            m.c0   = (CHANNELS > 0) ? 8'(sum[0] / (w * w)) : 8'd0;
            m.c1   = (CHANNELS > 1) ? 8'(sum[1] / (w * w)) : 8'd0;
            m.c2   = (CHANNELS > 2) ? 8'(sum[2] / (w * w)) : 8'd0;
            m.c3   = (CHANNELS > 3) ? 8'(sum[3] / (w * w)) : 8'd0;
            m.done = (o + 1 >= total);
            means_due.push_back(m);
            out_col++;
            if (out_col >= cols) begin
                out_col = 0;
                out_row++;
            end
            if (m.done) clear_pos();
        endfunction

        function void check(t_mean got);
            t_mean want;
            if (means_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h at %0t", got, $realtime);
                return;
            end
            want = means_due.pop_front();
            if (got.c0 !== want.c0 || got.c1 !== want.c1 || got.c2 !== want.c2 ||
                got.c3 !== want.c3 || got.done !== want.done) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t: want %h %h %h %h done %b, got %h %h %h %h done %b",
                             $realtime, want.c0, want.c1, want.c2, want.c3, want.done,
                             got.c0, got.c1, got.c2, got.c3, got.done);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    bfm_in_if  pix ();
    bfm_out_if res ();

    box_filter_mean_2d_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix.sink),
        .o_res      (res.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    mean_scoreboard sb = new();
    bit quiet;
    int idle_cycles;
    int sent_items;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Note requests and check results on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pix.valid && pix.ready)
                sb.note_pixel({pix.chan3, pix.chan2, pix.chan1, pix.chan0, pix.filler});
            if (res.valid && res.ready)
                sb.check({res.out_chan3, res.out_chan2, res.out_chan1, res.out_chan0,
                          res.frame_done});
            if ((pix.valid && pix.ready) || (res.valid && res.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        res.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 14);
    end

    // Valid stays up after acceptance until the next request or a drain lowers it
    task automatic send_pixel(t_pixel p);
        while (!quiet && $urandom_range(99) < 14) begin
            pix.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix.valid  <= 1'b1;
        pix.chan0  <= p.c0;
        pix.chan1  <= p.c1;
        pix.chan2  <= p.c2;
        pix.chan3  <= p.c3;
        pix.filler <= p.filler;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent_items++;
    endtask

    function automatic t_pixel rand_pixel(bit filler);
        t_pixel p;
        p        = t_pixel'($urandom());
        p.filler = filler;
        return p;
    endfunction

    // Hold until every expected result has come, then let the block settle
    task automatic drain_wait();
        pix.valid <= 1'b0;
        while (sb.means_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, bit [15:0] data);
        drain_wait();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_shape(bit [15:0] w, bit [15:0] c, bit [15:0] r);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_COLS, c);
        write_reg(CFG_ROWS, r);
    endtask

    // Send a whole frame: pixels with stray fillers, then fillers and noise until done
    task automatic run_frame(int fill_pct, bit extremes);
        int n;
        t_pixel p;
        n = sb.nrows() * sb.ncols();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < fill_pct) send_pixel(rand_pixel(1'b1));
            p = rand_pixel(1'b0);
            if (extremes) begin
                case ($urandom_range(2))
                    0: p = {32'h0000_0000, 1'b0};
                    1: p = {32'hffff_ffff, 1'b0};
                    default: ;
                endcase
            end
            send_pixel(p);
        end
        while (sb.frame_open()) send_pixel(rand_pixel($urandom_range(3) != 0));
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_WIDTH;
        i_cfg_data = '0;
        pix.valid  = 1'b0;
        pix.chan0  = '0;
        pix.chan1  = '0;
        pix.chan2  = '0;
        pix.chan3  = '0;
        pix.filler = 1'b0;
        quiet       = 1'b0;
        idle_cycles = 0;
        sent_items  = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: small frame with extreme pixels, fillers inside and noise while draining
        set_shape(16'd3, 16'd4, 16'd3);
        run_frame(20, 1'b1);
        // Width zero, columns zero and rows zero all collapse to one
        set_shape(16'd0, 16'd0, 16'd0);
        run_frame(0, 1'b1);
        // Window wider than the image; even width rounds up
        set_shape(16'd15, 16'd3, 16'd2);
        run_frame(10, 1'b1);
        set_shape(16'd14, 16'd2, 16'd2);
        run_frame(0, 1'b1);
        // Oversized column count clamps to the widest row; part of the row, then abandoned
        set_shape(16'hfff1, 16'hffff, 16'd1);
        repeat (40) send_pixel(rand_pixel(1'b0));
        // Tallest frame, abandoned by a register write
        set_shape(16'd1, 16'd1, 16'hffff);
        repeat (4) send_pixel(rand_pixel(1'b0));

        // Random frames, mostly small; a stretch with no idling on either side
        for (int f = 0; sent_items < 450; f++) begin
            quiet = (f >= 2 && f < 7);
            set_shape({12'($urandom_range(4095)), 4'($urandom_range(15))},
                      {4'($urandom()), 12'($urandom_range(12, 1))},
                      16'($urandom_range(8, 1)));
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(6, 1)) send_pixel(rand_pixel($urandom_range(9) == 0));
            end else begin
                run_frame(5, $urandom_range(3) == 0);
            end
            if (f == 3) drain_wait();
        end
        quiet = 1'b0;

        drain_wait();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.means_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
rtl/bfm_pkg.sv
rtl/bfm_in_if.sv
rtl/bfm_out_if.sv
rtl/bfm_ctrl.sv
rtl/bfm_datapath.sv
rtl/box_filter_mean_2d_unit.sv
tb/sv/tb_box_filter_mean_2d_unit.sv
